>>> hw/rtl/wlrc_pkg.sv
// wlrc_pkg: types, register indexes and reset values shared by the
// water level refill controller. No dependencies.
package wlrc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam int CONFIRM_LIMIT_DEFAULT = 3;
  localparam int RESERVOIR_CONFIRM_DEFAULT = 5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POND_HIGH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POND_MID = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POND_LOW = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RESERVOIR = 8'd3;

  localparam logic [SAMPLE_W-1:0] POND_HIGH_RESET = 10'd768;
  localparam logic [SAMPLE_W-1:0] POND_MID_RESET = 10'd512;
  localparam logic [SAMPLE_W-1:0] POND_LOW_RESET = 10'd256;
  localparam logic [SAMPLE_W-1:0] RESERVOIR_RESET = 10'd512;

  // pond bands
  localparam logic [1:0] BAND_EMPTY = 2'd0;
  localparam logic [1:0] BAND_LOW = 2'd1;
  localparam logic [1:0] BAND_MID = 2'd2;
  localparam logic [1:0] BAND_HIGH = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pond_sample;
    logic [SAMPLE_W-1:0] reservoir_sample;
    logic                waterfall_request;
    logic                irrigation_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0] pond_level;
    logic       level_flag_one;
    logic       level_flag_two;
    logic       reservoir_low;
    logic       refill_valve_on;
    logic       waterfall_on;
    logic       irrigation_on;
    logic       main_pump_on;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pond_high_threshold;
    logic [SAMPLE_W-1:0] pond_mid_threshold;
    logic [SAMPLE_W-1:0] pond_low_threshold;
    logic [SAMPLE_W-1:0] reservoir_threshold;
  } thresholds_t;

  typedef struct packed {
    logic [1:0] pond_level;
    logic       level_flag_one;
    logic       level_flag_two;
  } level_t;

  typedef struct packed {
    logic reservoir_low;
    logic refill_valve_on;
    logic waterfall_on;
    logic irrigation_on;
    logic main_pump_on;
  } actuators_t;

endpackage

>>> hw/rtl/wlrc_in_if.sv
// wlrc_in_if: sample channel, valid/ready with one input item per beat.
// Depends on wlrc_pkg.
interface wlrc_in_if;
  logic               valid;
  logic               ready;
  wlrc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/wlrc_out_if.sv
// wlrc_out_if: result channel, valid/ready with one result item per beat.
// Depends on wlrc_pkg.
interface wlrc_out_if;
  logic                valid;
  logic                ready;
  wlrc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/wlrc_cfg_if.sv
// wlrc_cfg_if: configuration write channel, register index and data per beat.
// Depends on wlrc_pkg.
interface wlrc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [wlrc_pkg::CFG_INDEX_W-1:0]     index;
  logic [wlrc_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/wlrc_cfg_regs.sv
// wlrc_cfg_regs: threshold registers written from the configuration channel.
// Depends on wlrc_pkg and wlrc_cfg_if.
module wlrc_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  wlrc_cfg_if.sink              cfg,
  output wlrc_pkg::thresholds_t thresholds
);

  wlrc_pkg::thresholds_t thr;
  logic [wlrc_pkg::SAMPLE_W-1:0] wr_value;

  assign cfg.ready = 1'b1;
  assign wr_value = cfg.data[wlrc_pkg::SAMPLE_W-1:0];
  assign thresholds = thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.pond_high_threshold <= wlrc_pkg::POND_HIGH_RESET;
      thr.pond_mid_threshold <= wlrc_pkg::POND_MID_RESET;
      thr.pond_low_threshold <= wlrc_pkg::POND_LOW_RESET;
      thr.reservoir_threshold <= wlrc_pkg::RESERVOIR_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        wlrc_pkg::REG_POND_HIGH: thr.pond_high_threshold <= wr_value;
        wlrc_pkg::REG_POND_MID: thr.pond_mid_threshold <= wr_value;
        wlrc_pkg::REG_POND_LOW: thr.pond_low_threshold <= wr_value;
        wlrc_pkg::REG_RESERVOIR: thr.reservoir_threshold <= wr_value;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/wlrc_band_filter.sv
// wlrc_band_filter: sorts the pond sample into a band and adopts a band
// after a run of confirming samples. Depends on wlrc_pkg.
module wlrc_band_filter #(
  parameter int CONFIRM_LIMIT = wlrc_pkg::CONFIRM_LIMIT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [wlrc_pkg::SAMPLE_W-1:0] pond_sample,
  input  wlrc_pkg::thresholds_t         thresholds,
  output wlrc_pkg::level_t              level
);

  localparam int CW = $clog2(CONFIRM_LIMIT + 1);

  logic [CW-1:0] run_count [4];
  logic [CW-1:0] run_count_next [4];
  logic [1:0]    adopted_level;
  logic [1:0]    adopted_level_next;
  logic [1:0]    band;
  logic [CW:0]   run_inc;

  always_comb begin
    if (pond_sample >= thresholds.pond_high_threshold) band = wlrc_pkg::BAND_HIGH;
    else if (pond_sample >= thresholds.pond_mid_threshold) band = wlrc_pkg::BAND_MID;
    else if (pond_sample >= thresholds.pond_low_threshold) band = wlrc_pkg::BAND_LOW;
    else band = wlrc_pkg::BAND_EMPTY;
  end

  always_comb begin
    run_inc = {1'b0, run_count[band]} + {{CW{1'b0}}, 1'b1};
    adopted_level_next = adopted_level;
    for (int k = 0; k < 4; k++) begin
      run_count_next[k] = '0;
    end
    if (run_inc > (CW + 1)'(CONFIRM_LIMIT)) begin
      adopted_level_next = band;
    end else begin
      run_count_next[band] = run_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adopted_level <= wlrc_pkg::BAND_EMPTY;
      for (int k = 0; k < 4; k++) begin
        run_count[k] <= '0;
      end
    end else if (step) begin
      adopted_level <= adopted_level_next;
      for (int k = 0; k < 4; k++) begin
        run_count[k] <= run_count_next[k];
      end
    end
  end

  // result reports the level after this sample
  assign level.pond_level = adopted_level_next;
  assign level.level_flag_one = adopted_level_next[1];
  assign level.level_flag_two = adopted_level_next[0];

endmodule

>>> hw/rtl/wlrc_actuator_logic.sv
// wlrc_actuator_logic: reservoir low confirmation, refill latch and
// valve/pump drive. Depends on wlrc_pkg.
module wlrc_actuator_logic #(
  parameter int RESERVOIR_CONFIRM = wlrc_pkg::RESERVOIR_CONFIRM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [wlrc_pkg::SAMPLE_W-1:0] reservoir_sample,
  input  logic [wlrc_pkg::SAMPLE_W-1:0] reservoir_threshold,
  input  logic                          waterfall_request,
  input  logic                          irrigation_request,
  input  wlrc_pkg::level_t              level,
  output wlrc_pkg::actuators_t          act
);

  localparam int RW = $clog2(RESERVOIR_CONFIRM + 1);

  logic [RW-1:0] low_count;
  logic [RW-1:0] low_count_next;
  logic [RW-1:0] low_inc;
  logic          refilling;
  logic          refilling_next;
  logic          low;
  logic          refill;
  logic          wf;
  logic          irr;

  always_comb begin
    low = 1'b0;
    low_inc = low_count;
    if (reservoir_sample > reservoir_threshold) begin
      if (low_count < RW'(RESERVOIR_CONFIRM)) low_inc = low_count + RW'(1);
      low = (low_inc >= RW'(RESERVOIR_CONFIRM));
      low_count_next = low ? RW'(RESERVOIR_CONFIRM) : low_inc;
    end else begin
      low_count_next = '0;
    end
  end

  always_comb begin
    refilling_next = refilling;
    refill = 1'b0;
    wf = 1'b0;
    irr = 1'b0;
    if (!low) begin
      // hysteresis: full pond stops, middle holds, low or empty starts
      if (level.level_flag_one && level.level_flag_two) begin
        refilling_next = 1'b0;
      end else if (refilling) begin
        refill = 1'b1;
      end else if (!level.level_flag_one) begin
        refilling_next = 1'b1;
        refill = 1'b1;
      end
      if (level.level_flag_one || level.level_flag_two) begin
        wf = waterfall_request;
        irr = irrigation_request;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_count <= '0;
      refilling <= 1'b0;
    end else if (step) begin
      low_count <= low_count_next;
      refilling <= refilling_next;
    end
  end

  assign act.reservoir_low = low;
  assign act.refill_valve_on = refill;
  assign act.waterfall_on = wf;
  assign act.irrigation_on = irr;
  assign act.main_pump_on = wf | irr;

endmodule

>>> hw/rtl/water_level_refill_controller.sv
// water_level_refill_controller: top level, input and result registers
// around the band filter and actuator logic.
// Depends on wlrc_pkg, the channel interfaces and all wlrc_* modules.
//
// Usage:
//   samples: one beat per tick while samples.ready is high carries the
//     pond and reservoir samples and the waterfall and irrigation requests.
//   results: one beat per accepted sample with the adopted pond level,
//     level flags, reservoir low flag and the valve and pump drives.
//   cfg: threshold writes by register index, always ready; write only
//     while no sample is in flight. Unknown indexes are ignored.
// A sample beat passes through the input register and then the result
// register to its result beat. Throughput is one item per cycle while the
// receiver is ready, set by the update of the run counters, reservoir
// count and refill latch that the next item reads.
// Reset clears both pipeline stages, all counters, the adopted level and
// the refill latch, and loads the default thresholds.
// When the receiver stalls the result register holds its beat, the input
// register fills behind it and then samples.ready drops until a beat leaves.
module water_level_refill_controller #(
  parameter int CONFIRM_LIMIT = wlrc_pkg::CONFIRM_LIMIT_DEFAULT,
  parameter int RESERVOIR_CONFIRM = wlrc_pkg::RESERVOIR_CONFIRM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  wlrc_in_if.sink     samples,
  wlrc_out_if.source  results,
  wlrc_cfg_if.sink    cfg
);

  wlrc_pkg::thresholds_t thresholds;
  wlrc_pkg::level_t      level;
  wlrc_pkg::actuators_t  act;
  wlrc_pkg::in_item_t    item;
  wlrc_pkg::out_item_t   result;
  logic                  item_valid;
  logic                  result_valid;
  logic                  out_free;
  logic                  step;

  assign out_free = !result_valid || results.ready;
  assign samples.ready = !item_valid || out_free;
  assign step = item_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (samples.ready) item_valid <= samples.valid;
      if (out_free) result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) item <= samples.data;
    if (step) begin
      result.pond_level <= level.pond_level;
      result.level_flag_one <= level.level_flag_one;
      result.level_flag_two <= level.level_flag_two;
      result.reservoir_low <= act.reservoir_low;
      result.refill_valve_on <= act.refill_valve_on;
      result.waterfall_on <= act.waterfall_on;
      result.irrigation_on <= act.irrigation_on;
      result.main_pump_on <= act.main_pump_on;
    end
  end

  assign results.valid = result_valid;
  assign results.data = result;

  wlrc_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .thresholds (thresholds)
  );

  wlrc_band_filter #(
    .CONFIRM_LIMIT (CONFIRM_LIMIT)
  ) u_band_filter (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .pond_sample (item.pond_sample),
    .thresholds  (thresholds),
    .level       (level)
  );

  wlrc_actuator_logic #(
    .RESERVOIR_CONFIRM (RESERVOIR_CONFIRM)
  ) u_actuator_logic (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .reservoir_sample    (item.reservoir_sample),
    .reservoir_threshold (thresholds.reservoir_threshold),
    .waterfall_request   (item.waterfall_request),
    .irrigation_request  (item.irrigation_request),
    .level               (level),
    .act                 (act)
  );

  // low reservoir beat must have every actuator off
  a_low_all_off: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.reservoir_low |->
      !results.data.refill_valve_on && !results.data.waterfall_on &&
      !results.data.irrigation_on && !results.data.main_pump_on)
    else $error("actuator on with reservoir low");

  // flags follow the reported level
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    results.valid |->
      results.data.level_flag_one == results.data.pond_level[1] &&
      results.data.level_flag_two == results.data.pond_level[0])
    else $error("level flags disagree with pond level");

  // empty pond keeps waterfall and irrigation closed
  a_empty_closed: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.pond_level == wlrc_pkg::BAND_EMPTY |->
      !results.data.waterfall_on && !results.data.irrigation_on)
    else $error("valve open on empty pond");

  // pipeline is empty the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !item_valid && !result_valid)
    else $error("pipeline not cleared by reset");

endmodule
